/* sv/pbq_pkg.sv */
package pbq_pkg;

  localparam int BAND_COUNT      = 64;
  localparam int BAND_W          = $clog2(BAND_COUNT);
  localparam int NUM_SLOTS       = 1024;
  localparam int SLOT_W          = $clog2(NUM_SLOTS);
  localparam int CNT_W           = $clog2(NUM_SLOTS + 1);
  localparam int LIMIT_W         = 10;
  localparam int CFG_IDX_W       = 1;
  localparam int FRAME_HDR_BYTES = 14;
  localparam int NET_HDR_BYTES   = 20;
  localparam int MIN_IP_LEN      = FRAME_HDR_BYTES + NET_HDR_BYTES;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_EVICTED  = 3'd1,
    ST_DROP_FUL = 3'd2,
    ST_DROP_ILL = 3'd3,
    ST_DEQUEUED = 3'd4,
    ST_PEEKED   = 3'd5,
    ST_EMPTY    = 3'd6,
    ST_DISABLED = 3'd7
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DQ_DISABLE  = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] packet_handle;
    logic [15:0] packet_length;
    logic [7:0]  tos_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [5:0]  out_band;
    logic [15:0] evicted_handle;
    logic [5:0]  evicted_band;
    logic [10:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic decide;
    logic push_rd;
    logic push_wr;
    logic pop_rd;
    logic pop_sel;
    logic pop_wr;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic go_push;
    logic go_pop;
    logic evict;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/pbq_ctrl.sv */
module pbq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbq_pkg::dp_stat_t stat,
  output pbq_pkg::dp_cmd_t  cmd
);
  import pbq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECIDE  = 8'b0000_0010,
    S_PUSH_RD = 8'b0000_0100,
    S_PUSH_WR = 8'b0000_1000,
    S_POP_RD  = 8'b0001_0000,
    S_POP_SEL = 8'b0010_0000,
    S_POP_WR  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && stat.clr_done;

  always_comb begin
    cmd         = '0;
    cmd.accept  = in_valid && in_ready;
    cmd.decide  = (state_r == S_DECIDE);
    cmd.push_rd = (state_r == S_PUSH_RD);
    cmd.push_wr = (state_r == S_PUSH_WR);
    cmd.pop_rd  = (state_r == S_POP_RD);
    cmd.pop_sel = (state_r == S_POP_SEL);
    cmd.pop_wr  = (state_r == S_POP_WR);
    cmd.emit    = (state_r == S_DONE) && stat.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.go_push)     state_nxt = S_PUSH_RD;
        else if (stat.go_pop) state_nxt = S_POP_RD;
        else                  state_nxt = S_DONE;
      end
      S_PUSH_RD: state_nxt = S_PUSH_WR;
      S_PUSH_WR: begin
        state_nxt = stat.evict ? S_POP_RD : S_DONE;
      end
      S_POP_RD:  state_nxt = S_POP_SEL;
      S_POP_SEL: state_nxt = S_POP_WR;
      S_POP_WR:  state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == S_DECIDE))
    else $error("accepted transaction did not reach decide");
  a_ready_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> stat.clr_done)
    else $error("ready during link clearing");
  a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_rd |=> cmd.push_wr)
    else $error("push write did not follow push read");

endmodule

/* sv/pbq_dp.sv */
module pbq_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pbq_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pbq_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pbq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pbq_pkg::LIMIT_W-1:0]          cfg_data,
  input  pbq_pkg::dp_cmd_t                     cmd,
  output pbq_pkg::dp_stat_t                    stat
);
  import pbq_pkg::*;

  logic [SLOT_W-1:0] next_mem   [NUM_SLOTS];
  logic [15:0]       handle_mem [NUM_SLOTS];
  logic [SLOT_W-1:0] head_mem   [BAND_COUNT];
  logic [SLOT_W-1:0] tail_mem   [BAND_COUNT];

  logic [LIMIT_W-1:0] limit_r;
  logic               dq_dis_r;
  logic [BAND_COUNT-1:0] occ_r;
  logic [SLOT_W-1:0]  free_head_r;
  logic [CNT_W-1:0]   total_r;
  logic [SLOT_W-1:0]  clr_cnt_r;
  logic               clr_done_r;

  cmd_t               cmd_r;
  logic [15:0]        handle_r;
  logic [BAND_W-1:0]  band_r;
  logic               illegal_r;
  logic [BAND_W-1:0]  pop_band_r;
  logic               evict_r;
  logic [SLOT_W-1:0]  pop_slot_r;
  logic               last_r;

  logic [SLOT_W-1:0]  next_rd_r, head_rd_r, tail_rd_r;
  logic [15:0]        handle_rd_r;

  status_t            res_status_r;
  logic [15:0]        res_oh_r, res_eh_r;
  logic [BAND_W-1:0]  res_ob_r, res_eb_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [BAND_W-1:0]  hi, low;
  logic               hi_valid, low_valid;
  logic [8:0]         band_full;
  logic               is_enq, is_deq, is_peek;
  logic               at_limit, drop, self_evict, go_push, go_pop;
  logic               band_occ;

  logic               next_we;
  logic [SLOT_W-1:0]  next_wa, next_wd, next_ra;
  logic               head_we;
  logic [SLOT_W-1:0]  head_wd;
  logic [BAND_W-1:0]  head_wa;

  always_comb begin
    hi = '0;
    hi_valid = 1'b0;
    for (int i = BAND_COUNT - 1; i >= 0; i--) begin
      if (occ_r[i]) begin
        hi = BAND_W'(i);
        hi_valid = 1'b1;
      end
    end
  end

  always_comb begin
    low = '0;
    low_valid = 1'b0;
    for (int i = 0; i < BAND_COUNT; i++) begin
      if (occ_r[i]) begin
        low = BAND_W'(i);
        low_valid = 1'b1;
      end
    end
  end

  assign band_full  = (in_data.packet_length < 16'(MIN_IP_LEN)) ? 9'd0
                                                                : {1'b0, in_data.tos_value};
  assign is_enq     = (cmd_r == CMD_ENQ);
  assign is_deq     = (cmd_r == CMD_DEQ);
  assign is_peek    = (cmd_r == CMD_PEEK);
  assign at_limit   = (total_r >= CNT_W'(limit_r));
  assign drop       = at_limit && low_valid && (low <= band_r);
  assign self_evict = at_limit && !low_valid;
  assign go_push    = is_enq && !illegal_r && !drop && !self_evict;
  assign go_pop     = (is_deq && !dq_dis_r && hi_valid) || (is_peek && hi_valid);
  assign band_occ   = occ_r[band_r];

  assign stat.clr_done = clr_done_r;
  assign stat.go_push  = go_push;
  assign stat.go_pop   = go_pop;
  assign stat.evict    = evict_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    next_we = 1'b0;
    next_wa = pop_slot_r;
    next_wd = free_head_r;
    if (!clr_done_r) begin
      next_we = 1'b1;
      next_wa = clr_cnt_r;
      next_wd = SLOT_W'(clr_cnt_r + 1'b1);
    end else if (cmd.push_wr && band_occ) begin
      next_we = 1'b1;
      next_wa = tail_rd_r;
    end else if (cmd.pop_wr && !is_peek) begin
      next_we = 1'b1;
    end
  end

  assign next_ra = cmd.push_rd ? free_head_r : head_rd_r;

  always_comb begin
    head_we = 1'b0;
    head_wa = band_r;
    head_wd = free_head_r;
    if (cmd.push_wr && !band_occ) begin
      head_we = 1'b1;
    end else if (cmd.pop_wr && !is_peek && !last_r) begin
      head_we = 1'b1;
      head_wa = pop_band_r;
      head_wd = next_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_r <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_rd) handle_mem[free_head_r] <= handle_r;
    handle_rd_r <= handle_mem[head_rd_r];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[pop_band_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_wr) tail_mem[band_r] <= free_head_r;
    tail_rd_r <= tail_mem[cmd.push_rd ? band_r : pop_band_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r     <= cmd_t'(in_data.command);
      handle_r  <= in_data.packet_handle;
      band_r    <= BAND_W'(band_full);
      illegal_r <= (band_full >= 9'(BAND_COUNT));
    end
    if (cmd.decide) begin
      pop_band_r <= is_enq ? low : hi;
      res_oh_r   <= '0;
      res_ob_r   <= '0;
      res_eh_r   <= '0;
      res_eb_r   <= '0;
      case (cmd_r)
        CMD_ENQ: begin
          if (illegal_r) begin
            res_status_r <= ST_DROP_ILL;
          end else if (drop) begin
            res_status_r <= ST_DROP_FUL;
          end else if (self_evict) begin
            res_status_r <= ST_EVICTED;
            res_ob_r     <= band_r;
            res_eh_r     <= handle_r;
            res_eb_r     <= band_r;
          end else begin
            res_status_r <= at_limit ? ST_EVICTED : ST_STORED;
            res_ob_r     <= band_r;
          end
        end
        CMD_DEQ: begin
          if (dq_dis_r)      res_status_r <= ST_DISABLED;
          else if (hi_valid) res_status_r <= ST_DEQUEUED;
          else               res_status_r <= ST_EMPTY;
        end
        CMD_PEEK: begin
          res_status_r <= hi_valid ? ST_PEEKED : ST_EMPTY;
        end
        default: res_status_r <= ST_EMPTY;
      endcase
    end
    if (cmd.pop_sel) begin
      pop_slot_r <= head_rd_r;
      last_r     <= (head_rd_r == tail_rd_r);
    end
    if (cmd.pop_wr) begin
      if (is_enq) begin
        res_eh_r <= handle_rd_r;
        res_eb_r <= pop_band_r;
      end else begin
        res_oh_r <= handle_rd_r;
        res_ob_r <= pop_band_r;
      end
    end
    if (cmd.emit) begin
      out_data_r.status         <= res_status_r;
      out_data_r.out_handle     <= res_oh_r;
      out_data_r.out_band       <= 6'(res_ob_r);
      out_data_r.evicted_handle <= res_eh_r;
      out_data_r.evicted_band   <= 6'(res_eb_r);
      out_data_r.occupancy      <= 11'(total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      dq_dis_r    <= 1'b0;
      occ_r       <= '0;
      free_head_r <= '0;
      total_r     <= '0;
      clr_cnt_r   <= '0;
      clr_done_r  <= 1'b0;
      evict_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_QUEUE_LIMIT: limit_r  <= cfg_data;
          CFG_DQ_DISABLE:  dq_dis_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (!clr_done_r) begin
        clr_cnt_r <= SLOT_W'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == SLOT_W'(NUM_SLOTS - 1)) clr_done_r <= 1'b1;
      end
      if (cmd.decide) evict_r <= is_enq && at_limit;
      if (cmd.push_wr) begin
        occ_r[band_r] <= 1'b1;
        free_head_r   <= next_rd_r;
        total_r       <= CNT_W'(total_r + 1'b1);
      end
      if (cmd.pop_wr && !is_peek) begin
        if (last_r) occ_r[pop_band_r] <= 1'b0;
        free_head_r <= pop_slot_r;
        total_r     <= CNT_W'(total_r - 1'b1);
      end
      if (cmd.emit)        out_valid_r <= 1'b1;
      else if (out_ready)  out_valid_r <= 1'b0;
    end
  end

  a_occ_total: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) == (total_r == '0))
    else $error("band bitmap and holding count disagree");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");
  a_push_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_wr || cmd.pop_wr) |-> clr_done_r)
    else $error("list update during link clearing");

endmodule

/* sv/priority_band_queue_with_evict_unit.sv */
// A result is registered after its transaction is accepted, passing these states:
// drop or empty: decide, done; store: decide, push read, push write, done; dequeue
// or peek: decide, pop read, pop select, pop write, done; store with eviction: push
// and pop states. One transaction at a time; the next after the result is loaded.
// Reset (rst_n, synchronous): all bands empty, limit 1023; then a pass over every slot
// rebuilds the free-slot links, during which no transaction is accepted.
module priority_band_queue_with_evict_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pbq_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pbq_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pbq_pkg::LIMIT_W-1:0]   cfg_data
);
  import pbq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pbq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pbq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* bench/tb_top.sv */
module tb_top;
  import pbq_pkg::*;

  class band_queue_scoreboard;
    bit [63:0] occupied;
    int head[64];
    int tail[64];
    int link[1024];
    int handle_of[1024];
    int free_slot;
    int held;
    int limit;
    bit deq_off;
    out_item_t pending[$];
    int errors;
    int checked;
    int evictions;
    int drops;

    function void clear();
      occupied = '0;
      foreach (link[i]) link[i] = (i + 1) % 1024;
      free_slot = 0;
      held = 0;
      limit = 1023;
      deq_off = 0;
    endfunction

    function int lowest_band();
      for (int b = 63; b >= 0; b--) if (occupied[b]) return b;
      return -1;
    endfunction

    function int highest_band();
      for (int b = 0; b < 64; b++) if (occupied[b]) return b;
      return -1;
    endfunction

    function void push_tail(int band, int h);
      int s;
      s = free_slot;
      free_slot = link[s];
      handle_of[s] = h;
      if (occupied[band]) begin
        link[tail[band]] = s;
        tail[band] = s;
      end else begin
        head[band] = s;
        tail[band] = s;
        occupied[band] = 1;
      end
      held++;
    endfunction

    function int pop_head(int band);
      int s;
      int h;
      s = head[band];
      h = handle_of[s];
      if (s == tail[band]) occupied[band] = 0;
      else head[band] = link[s];
      link[s] = free_slot;
      free_slot = s;
      if (held > 0) held--;
      return h;
    endfunction

    function void note_command(in_item_t it);
      out_item_t r;
      int band;
      int low;
      int hi;
      bit no_slot;
      r = '0;
      r.status = ST_EMPTY;
      case (cmd_t'(it.command))
        CMD_ENQ: begin
          band = (it.packet_length < MIN_IP_LEN) ? 0 : int'(it.tos_value);
          if (band >= BAND_COUNT) begin
            r.status = ST_DROP_ILL;
          end else begin
            low = lowest_band();
            no_slot = held >= NUM_SLOTS;
            if ((held >= limit || no_slot) && low >= 0 && low <= band) begin
              r.status = ST_DROP_FUL;
            end else begin
              r.status = ST_STORED;
              r.out_band = 6'(band);
              if (no_slot && low >= 0) begin
                r.evicted_handle = 16'(pop_head(low));
                r.evicted_band = 6'(low);
                r.status = ST_EVICTED;
              end
              push_tail(band, int'(it.packet_handle));
              if (r.status == ST_STORED && held > limit) begin
                low = lowest_band();
                if (low >= 0) begin
                  r.evicted_handle = 16'(pop_head(low));
                  r.evicted_band = 6'(low);
                  r.status = ST_EVICTED;
                end
              end
            end
          end
        end
        CMD_DEQ: begin
          if (deq_off) begin
            r.status = ST_DISABLED;
          end else begin
            hi = highest_band();
            if (hi >= 0) begin
              r.out_handle = 16'(pop_head(hi));
              r.out_band = 6'(hi);
              r.status = ST_DEQUEUED;
            end
          end
        end
        CMD_PEEK: begin
          hi = highest_band();
          if (hi >= 0) begin
            r.out_handle = 16'(handle_of[head[hi]]);
            r.out_band = 6'(hi);
            r.status = ST_PEEKED;
          end
        end
        default: ;
      endcase
      if (r.status == ST_EVICTED) evictions++;
      if (r.status == ST_DROP_FUL || r.status == ST_DROP_ILL) drops++;
      r.occupancy = 11'(held);
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.out_handle !== e.out_handle) begin
        $error("out_handle: expected %h, got %h", e.out_handle, got.out_handle); errors++;
      end
      if (got.out_band !== e.out_band) begin
        $error("out_band: expected %0d, got %0d", e.out_band, got.out_band); errors++;
      end
      if (got.evicted_handle !== e.evicted_handle) begin
        $error("evicted_handle: expected %h, got %h", e.evicted_handle, got.evicted_handle);
        errors++;
      end
      if (got.evicted_band !== e.evicted_band) begin
        $error("evicted_band: expected %0d, got %0d", e.evicted_band, got.evicted_band);
        errors++;
      end
      if (got.occupancy !== e.occupancy) begin
        $error("occupancy: expected %0d, got %0d", e.occupancy, got.occupancy); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  band_queue_scoreboard sb = new();
  bit quiet = 0;
  int hold_cycles = 0;
  int idle_count = 0;
  int sent = 0;

  priority_band_queue_with_evict_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(out_data);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > 20000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_cmd(in_item_t it);
    if (!quiet && $urandom_range(0, 99) < 29) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_command(it);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= LIMIT_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CFG_QUEUE_LIMIT) sb.limit = val;
    else sb.deq_off = val[0];
  endtask

  function automatic in_item_t mk(cmd_t c, int h, int len, int tos);
    in_item_t it;
    it.command = c;
    it.packet_handle = 16'(h);
    it.packet_length = 16'(len);
    it.tos_value = 8'(tos);
    return it;
  endfunction

  function automatic in_item_t rand_cmd();
    int r;
    int tos;
    int len;
    r = $urandom_range(0, 99);
    tos = $urandom_range(0, 9) < 7 ? $urandom_range(0, 7) :
          ($urandom_range(0, 2) < 2 ? $urandom_range(0, 63) : $urandom_range(0, 255));
    len = $urandom_range(0, 4) == 0 ? $urandom_range(0, 33) : $urandom_range(0, 65535);
    return mk(r < 55 ? CMD_ENQ : r < 80 ? CMD_DEQ : r < 95 ? CMD_PEEK : CMD_NOP,
              $urandom_range(0, 65535), len, tos);
  endfunction

  int limits[8] = '{3, 1023, 0, 8, 1, 40, 1022, 1023};

  initial begin
    sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_cmd(mk(CMD_PEEK, 0, 0, 0));
    send_cmd(mk(CMD_DEQ, 0, 0, 0));
    send_cmd(mk(CMD_NOP, 16'hFFFF, 16'hFFFF, 255));
    send_cmd(mk(CMD_ENQ, 16'h1234, 33, 200));
    send_cmd(mk(CMD_ENQ, 16'hFFFF, 34, 63));
    send_cmd(mk(CMD_ENQ, 16'h0000, 100, 64));
    send_cmd(mk(CMD_ENQ, 16'hAAAA, 16'hFFFF, 255));
    send_cmd(mk(CMD_ENQ, 16'h5555, 16'hFFFF, 5));
    send_cmd(mk(CMD_PEEK, 0, 0, 0));
    send_cmd(mk(CMD_DEQ, 0, 0, 0));
    wait_drained();
    write_reg(CFG_DQ_DISABLE, 1);
    send_cmd(mk(CMD_DEQ, 0, 0, 0));
    send_cmd(mk(CMD_PEEK, 0, 0, 0));
    wait_drained();
    write_reg(CFG_DQ_DISABLE, 0);
    send_cmd(mk(CMD_DEQ, 0, 0, 0));
    send_cmd(mk(CMD_DEQ, 0, 0, 0));
    send_cmd(mk(CMD_DEQ, 0, 0, 0));
    wait_drained();
    write_reg(CFG_QUEUE_LIMIT, 0);
    send_cmd(mk(CMD_ENQ, 16'h0F0F, 60, 9));
    wait_drained();
    write_reg(CFG_QUEUE_LIMIT, 1023);
    for (int i = 0; i < 5; i++) send_cmd(mk(CMD_ENQ, i, 60, 10 + i));
    wait_drained();
    write_reg(CFG_QUEUE_LIMIT, 2);
    send_cmd(mk(CMD_ENQ, 16'h00F0, 60, 1));
    send_cmd(mk(CMD_ENQ, 16'h0F00, 60, 40));

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_reg(CFG_QUEUE_LIMIT, limits[p]);
      write_reg(CFG_DQ_DISABLE, int'($urandom_range(0, 5) == 0));
      quiet = (p == 3);
      for (int i = 0; i < 210; i++) begin
        if (p == 1 && i == 50) hold_cycles = 300;
        if (p == 2 && i == 100) wait_drained();
        send_cmd(rand_cmd());
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d commands sent, %0d results checked, %0d evictions, %0d drops",
             sent, sb.checked, sb.evictions, sb.drops);
    $display("limits 0 to 1023 and dequeue disable both ways were exercised");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

/* files.f */
sv/pbq_pkg.sv
sv/pbq_ctrl.sv
sv/pbq_dp.sv
sv/priority_band_queue_with_evict_unit.sv
bench/tb_top.sv
